@@ sv/ivd_pkg.sv @@
// shared types and constants for the afsk interval vote deframer
// no dependencies; imported by every module of the block
package ivd_pkg;

    localparam int TICK_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int BIT_CNT_W  = 4;

    localparam int VOTES_PER_BIT_DEF = 3;

    localparam logic [TICK_W-1:0] MIN_TICKS_RST   = 16'd300;
    localparam logic [TICK_W-1:0] MAX_TICKS_RST   = 16'd1100;
    localparam logic [TICK_W-1:0] SPLIT_TICKS_RST = 16'd644;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_IDX = 2'd2;

    localparam logic [BIT_CNT_W-1:0] DATA_BITS = 4'd8;

    typedef enum logic [1:0] {
        TONE_BAD   = 2'd0,
        TONE_LONG  = 2'd1,  // long interval, low tone
        TONE_SHORT = 2'd2   // short interval, high tone
    } tone_t;

    // one judged group of votes
    typedef struct packed {
        logic valid;    // group complete this transfer
        logic agree;    // all members valid and equal
        logic bit_val;  // high tone means 1
    } bit_evt_t;

endpackage

@@ sv/afsk_interval_vote_deframer_top.sv @@
// a result passes through the input reg and then the result reg after its interval transfer
// throughput: one interval per cycle while the output is not stalled, set by the single compare-vote-shift pass
// the input side stalls only while a held result waits on a stalled output
// reset (rst_n, async, active low): config back to 300/1100/644, vote group and frame idle
// depends on ivd_pkg, ivd_classify, ivd_vote, ivd_frame
module afsk_interval_vote_deframer_top #(
    parameter int VOTES_PER_BIT = ivd_pkg::VOTES_PER_BIT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [ivd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ivd_pkg::TICK_W-1:0]    cfg_data,
    // interval input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ivd_pkg::TICK_W-1:0]    interval_ticks,
    // byte output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ivd_pkg::BYTE_W-1:0]    data_byte
);
    import ivd_pkg::*;

    // config registers
    logic [TICK_W-1:0] min_ticks_reg;
    logic [TICK_W-1:0] max_ticks_reg;
    logic [TICK_W-1:0] split_ticks_reg;

    // input register
    logic              s1_valid_reg;
    logic [TICK_W-1:0] s1_ticks_reg;

    // result register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] data_byte_reg;

    logic              advance;
    tone_t             tone;
    bit_evt_t          evt;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;

    // the held item moves on when the result register is free or being drained
    assign advance  = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = s1_valid_reg & ~advance;

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;

    // config writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ticks_reg   <= MIN_TICKS_RST;
            max_ticks_reg   <= MAX_TICKS_RST;
            split_ticks_reg <= SPLIT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_IDX:   min_ticks_reg   <= cfg_data;
                CFG_MAX_IDX:   max_ticks_reg   <= cfg_data;
                CFG_SPLIT_IDX: split_ticks_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input register: loads on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_ticks_reg <= interval_ticks;
        end
    end

    // classify the held interval against the window and split
    ivd_classify u_classify (
        .ticks       (s1_ticks_reg),
        .min_ticks   (min_ticks_reg),
        .max_ticks   (max_ticks_reg),
        .split_ticks (split_ticks_reg),
        .tone        (tone)
    );

    // group vote, one member per advancing item
    ivd_vote #(
        .VOTES_PER_BIT (VOTES_PER_BIT)
    ) u_vote (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .tone  (tone),
        .evt   (evt)
    );

    // framing and parity; evt.valid is already qualified by advance
    ivd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .emit      (emit),
        .emit_byte (emit_byte)
    );

    // result register: loads a checked byte, clears once its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            data_byte_reg <= emit_byte;
        end
    end

endmodule

@@ sv/ivd_classify.sv @@
// interval classifier: window check and low/high split
// depends on ivd_pkg
module ivd_classify (
    input  logic [ivd_pkg::TICK_W-1:0] ticks,
    input  logic [ivd_pkg::TICK_W-1:0] min_ticks,
    input  logic [ivd_pkg::TICK_W-1:0] max_ticks,
    input  logic [ivd_pkg::TICK_W-1:0] split_ticks,
    output ivd_pkg::tone_t             tone
);
    import ivd_pkg::*;

    always_comb
    begin
        if ((ticks < min_ticks) || (ticks > max_ticks))
        begin
            tone = TONE_BAD;
        end
        else if (ticks > split_ticks)
        begin
            tone = TONE_LONG;
        end
        else
        begin
            tone = TONE_SHORT;
        end
    end

endmodule

@@ sv/ivd_vote.sv @@
// group voting: running agreement over non-overlapping groups of tones
// depends on ivd_pkg
module ivd_vote #(
    parameter int VOTES_PER_BIT = ivd_pkg::VOTES_PER_BIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ivd_pkg::tone_t    tone,
    output ivd_pkg::bit_evt_t evt
);
    import ivd_pkg::*;

    localparam int VPOS_W = (VOTES_PER_BIT > 1) ? $clog2(VOTES_PER_BIT) : 1;
    localparam logic [VPOS_W-1:0] LAST_POS = VPOS_W'(VOTES_PER_BIT - 1);

    logic [VPOS_W-1:0] pos_reg, pos_next;
    logic              all_low_reg, all_low_next;
    logic              all_high_reg, all_high_next;
    logic              first, last;

    always_comb
    begin
        first         = (pos_reg == '0);
        last          = (pos_reg == LAST_POS);
        // a bad member clears both flags, so the group cannot agree
        all_low_next  = (first | all_low_reg) & (tone == TONE_LONG);
        all_high_next = (first | all_high_reg) & (tone == TONE_SHORT);
        pos_next      = last ? '0 : pos_reg + VPOS_W'(1);

        evt.valid   = step & last;
        evt.agree   = all_low_next | all_high_next;
        evt.bit_val = all_high_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            all_low_reg  <= 1'b0;
            all_high_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            all_low_reg  <= all_low_next;
            all_high_reg <= all_high_next;
        end
    end

endmodule

@@ sv/ivd_frame.sv @@
// deframer: start bit, 8 data bits lsb first, even parity check
// depends on ivd_pkg
module ivd_frame (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ivd_pkg::bit_evt_t          evt,
    output logic                       emit,
    output logic [ivd_pkg::BYTE_W-1:0] emit_byte
);
    import ivd_pkg::*;

    logic                 in_frame_reg, in_frame_next;
    logic [BIT_CNT_W-1:0] bits_reg, bits_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        bits_next     = bits_reg;
        shift_next    = shift_reg;
        emit          = 1'b0;
        emit_byte     = shift_reg;

        if (evt.valid)
        begin
            if (!evt.agree)
            begin
                in_frame_next = 1'b0;
                bits_next     = '0;
                shift_next    = '0;
            end
            else if (!in_frame_reg)
            begin
                // only a 0 bit opens a frame
                if (!evt.bit_val)
                begin
                    in_frame_next = 1'b1;
                    bits_next     = '0;
                    shift_next    = '0;
                end
            end
            else if (bits_reg < DATA_BITS)
            begin
                shift_next = shift_reg | (BYTE_W'(evt.bit_val) << bits_reg[2:0]);
                bits_next  = bits_reg + BIT_CNT_W'(1);
            end
            else
            begin
                // parity bit: frame always ends here
                emit          = ((^shift_reg) == evt.bit_val);
                in_frame_next = 1'b0;
                bits_next     = '0;
                shift_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            bits_reg     <= '0;
            shift_reg    <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            bits_reg     <= bits_next;
            shift_reg    <= shift_next;
        end
    end

endmodule

@@ sv/ivd_checker.sv @@
// port-level checks for the deframer top, attached by bind
// depends on ivd_pkg and afsk_interval_vote_deframer_top
module ivd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [ivd_pkg::BYTE_W-1:0]    data_byte
);
    import ivd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its byte
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(data_byte))
        else $error("result byte changed while stalled");

    // the input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a fresh result follows an earlier input transfer, through the input reg and the result reg
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without an input transfer");

endmodule

bind afsk_interval_vote_deframer_top ivd_checker u_ivd_checker (.*);
